// File: hw/rtl/mud64_pkg.sv
package mud64_pkg;

    // Datagram limits
    localparam int MAX_PACKET_BYTES = 1400;
    localparam int POS_W            = 11;
    localparam int HDR_SESSION      = 10;
    localparam int HDR_SEQ_END      = 18;
    localparam int HDR_TOTAL        = 20;

    localparam int TDATA_W = 144;
    localparam int TUSER_W = 3;

    typedef enum logic [2:0] {
        KIND_SESSION  = 3'd0,
        KIND_SEQUENCE = 3'd1,
        KIND_COUNT    = 3'd2,
        KIND_MSG_LEN  = 3'd3,
        KIND_PAYLOAD  = 3'd4,
        KIND_IGNORED  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_SHORT_HDR   = 2'd1,
        ST_PART_MSGHDR = 2'd2,
        ST_PART_DATA   = 2'd3
    } t_status;

    // One input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One result item
    typedef struct packed {
        t_kind       byte_kind;
        logic [7:0]  byte_value;
        logic [15:0] message_index;
        logic [15:0] msg_length;
        logic [15:0] payload_offset;
        logic        message_end;
        logic        header_done;
        logic [63:0] sequence_number;
        logic [15:0] message_count;
        logic        packet_end;
        t_status     status;
    } t_result;

endpackage

// File: hw/rtl/mud64_in_stage.sv
module mud64_in_stage
    import mud64_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    output logic     o_valid,
    output t_in_item o_item,
    input  logic     i_ready
);

    logic     r_valid;
    t_in_item r_item;

    // Register frees up whenever the downstream takes the held item
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hw/rtl/mud64_parser.sv
module mud64_parser
    import mud64_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    output logic     o_valid,
    output t_result  o_result,
    input  logic     i_ready
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    logic [POS_W-1:0] r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic [63:0]      r_seq, n_seq;
    logic [15:0]      r_count, n_count;
    logic [15:0]      r_msgs, n_msgs;
    logic [15:0]      r_cur_len, n_cur_len;
    logic [15:0]      r_left, n_left;
    logic [7:0]       r_len_hi, n_len_hi;

    logic    r_out_valid;
    t_result r_out, n_out;

    logic        take;
    logic [7:0]  b;
    logic [15:0] msgs_inc;
    logic [15:0] new_len;
    logic [15:0] left_dec;
    logic        hdone;

    assign o_ready  = !r_out_valid || i_ready;
    assign take     = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign b        = i_item.data_byte;
    assign msgs_inc = r_msgs + 16'd1;
    assign new_len  = {r_len_hi, b};
    assign left_dec = r_left - 16'd1;

    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_seq     = r_seq;
        n_count   = r_count;
        n_msgs    = r_msgs;
        n_cur_len = r_cur_len;
        n_left    = r_left;
        n_len_hi  = r_len_hi;

        n_out                = '0;
        n_out.byte_kind      = KIND_IGNORED;
        n_out.byte_value     = b;
        n_out.packet_end     = i_item.last_byte;
        n_out.status         = ST_OK;

        if (r_pos < POS_W'(MAX_PACKET_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos < POS_W'(HDR_SESSION)) begin
                        n_out.byte_kind = KIND_SESSION;
                    end else if (r_pos < POS_W'(HDR_SEQ_END)) begin
                        n_out.byte_kind = KIND_SEQUENCE;
                        n_seq = {r_seq[55:0], b};
                    end else begin
                        n_out.byte_kind = KIND_COUNT;
                        n_count = {r_count[7:0], b};
                        if (r_pos == POS_W'(HDR_TOTAL - 1)) begin
                            n_phase = ({r_count[7:0], b} == 16'd0) ? PH_DONE : PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_HI: begin
                    n_out.byte_kind     = KIND_MSG_LEN;
                    n_out.message_index = r_msgs;
                    n_len_hi = b;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_out.byte_kind      = KIND_MSG_LEN;
                    n_out.message_index  = r_msgs;
                    n_out.msg_length     = new_len;
                    n_cur_len = new_len;
                    if (new_len == 16'd0) begin
                        // empty message ends on its second length byte
                        n_out.message_end = 1'b1;
                        n_msgs  = msgs_inc;
                        n_phase = (msgs_inc == r_count) ? PH_DONE : PH_LEN_HI;
                    end else begin
                        n_left  = new_len;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_out.byte_kind      = KIND_PAYLOAD;
                    n_out.message_index  = r_msgs;
                    n_out.msg_length     = r_cur_len;
                    n_out.payload_offset = r_cur_len - r_left;
                    n_left = left_dec;
                    if (left_dec == 16'd0) begin
                        n_out.message_end = 1'b1;
                        n_msgs  = msgs_inc;
                        n_phase = (msgs_inc == r_count) ? PH_DONE : PH_LEN_HI;
                    end
                end
                default: begin
                    n_out.byte_kind = KIND_IGNORED;
                end
            endcase
        end

        hdone = (n_phase != PH_HEADER);
        n_out.header_done     = hdone;
        n_out.sequence_number = hdone ? n_seq : 64'd0;
        n_out.message_count   = hdone ? n_count : 16'd0;

        if (i_item.last_byte) begin
            case (n_phase)
                PH_HEADER:  n_out.status = ST_SHORT_HDR;
                PH_LEN_HI:  n_out.status = ST_PART_MSGHDR;
                PH_LEN_LO:  n_out.status = ST_PART_MSGHDR;
                PH_PAYLOAD: n_out.status = ST_PART_DATA;
                default:    n_out.status = ST_OK;
            endcase
            // fresh state for the next datagram
            n_pos     = '0;
            n_phase   = PH_HEADER;
            n_seq     = '0;
            n_count   = '0;
            n_msgs    = '0;
            n_cur_len = '0;
            n_left    = '0;
            n_len_hi  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_phase     <= PH_HEADER;
            r_seq       <= '0;
            r_count     <= '0;
            r_msgs      <= '0;
            r_cur_len   <= '0;
            r_left      <= '0;
            r_len_hi    <= '0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (take) begin
                r_pos     <= n_pos;
                r_phase   <= n_phase;
                r_seq     <= n_seq;
                r_count   <= n_count;
                r_msgs    <= n_msgs;
                r_cur_len <= n_cur_len;
                r_left    <= n_left;
                r_len_hi  <= n_len_hi;
            end
        end
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hw/rtl/moldudp64_packet_deframer.sv
// MoldUDP64 deframer. Feed the UDP payload one byte per item on the slave
// stream with tlast on the final byte of the datagram; every byte comes back
// as exactly one result item, labelled in tuser with its role (session,
// sequence, count, message length, payload, ignored) and carrying in tdata
// the message index, declared length, payload offset, end-of-message flag,
// the assembled header fields once the 20-byte header is complete, and on
// tlast a status (ok, short header, incomplete message header, incomplete
// data). Payload is forwarded as it arrives, so truncation is only reported
// at the end. Bytes past the counted messages or past MAX_PACKET_BYTES
// (1400) are marked ignored. Throughput is one byte per cycle while results
// are taken; each byte passes through one input register, then the parse
// logic (phase, 16-bit counters and subtracts) feeding the result register.
// While a result waits downstream the parser holds, the input register takes
// one more item and then tready drops until the result is taken.
module moldudp64_packet_deframer
    import mud64_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // data_byte[7:0]
    input  logic               i_s_axis_tlast,   // last_byte
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // byte_value[7:0], message_index[23:8], msg_length[39:24],
    // payload_offset[55:40], message_end[56], header_done[57],
    // sequence_number[121:58], message_count[137:122], status[139:138],
    // zero pad[143:140]
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic [TUSER_W-1:0] o_m_axis_tuser,   // byte_kind[2:0]
    output logic               o_m_axis_tlast    // packet_end
);

    t_in_item in_item;
    t_in_item stg_item;
    logic     stg_valid;
    logic     stg_ready;
    t_result  res;

    assign in_item.data_byte = i_s_axis_tdata;
    assign in_item.last_byte = i_s_axis_tlast;

    // input register
    mud64_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_item  (in_item),
        .o_ready (o_s_axis_tready),
        .o_valid (stg_valid),
        .o_item  (stg_item),
        .i_ready (stg_ready)
    );

    // header/message tracking and result register
    mud64_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stg_valid),
        .i_item   (stg_item),
        .o_ready  (stg_ready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (res),
        .i_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {4'd0,
                             res.status,
                             res.message_count,
                             res.sequence_number,
                             res.header_done,
                             res.message_end,
                             res.payload_offset,
                             res.msg_length,
                             res.message_index,
                             res.byte_value};
    assign o_m_axis_tuser = res.byte_kind;
    assign o_m_axis_tlast = res.packet_end;

endmodule
